FILE: rtl/pbb_pkg.sv
`default_nettype none
package pbb_pkg;

  localparam int COORD_W   = 32;
  localparam int MARGIN_W  = 31;
  localparam int COUNT_W   = 7;
  localparam int BOX_W     = 6;
  localparam int SLOT_W    = 6;
  localparam int POINT_W   = 16;
  localparam int CLASS_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam int MAX_SLOTS = 64;
  localparam int MAX_SCAN  = 64;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PLACE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 2'd2;

  localparam logic [CLASS_W-1:0] CLS_INNER = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_BAND  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_HALO  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_FULL  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_NOBOX = 3'd4;

  typedef struct packed {
    logic [1:0]                kind;
    logic [BOX_W-1:0]          box_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] coord_x_hi;
    logic signed [COORD_W-1:0] coord_y_hi;
    logic signed [COORD_W-1:0] coord_z_hi;
    logic [POINT_W-1:0]        point_id;
  } in_item_t;

  typedef struct packed {
    logic [BOX_W-1:0]          out_box;
    logic [SLOT_W-1:0]         out_slot;
    logic [POINT_W-1:0]        out_point;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [CLASS_W-1:0]        place_class;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] hi_z;
  } box_t;

  typedef struct packed {
    logic               hit;
    logic               full;
    logic [CLASS_W-1:0] cls;
  } hit_t;

endpackage
`default_nettype wire

FILE: rtl/pbb_in_if.sv
`default_nettype none
interface pbb_in_if;
  logic              valid;
  logic              ready;
  pbb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pbb_out_if.sv
`default_nettype none
interface pbb_out_if;
  logic               valid;
  logic               ready;
  pbb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/point_box_binning_with_halo.sv
`default_nettype none
// Channel   Dir  Transfer when        Payload
// in_chan   in   valid && ready       kind, box_index, coords, point_id
// out_chan  out  valid && ready       out_box .. last
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// Load, clear and unused kinds are taken while idle and leave the block idle. A point
// holds the input until its scan ends; the scan covers box_count boxes, capped at
// MAX_BOXES and at 64, and stops at the first full box that is hit. One box per
// cycle, unless stalled, through the shared hit unit behind the registered table read.
// Synchronous active-low reset restores config defaults, clears fill counts and control.
// A stalled output holds the scan at the next hit.
module point_box_binning_with_halo #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pbb_in_if.sink                               in_chan,
  pbb_out_if.source                            out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [pbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pbb_pkg::CFG_W-1:0]       cfg_data
);
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int LIM   = (MAX_BOXES < pbb_pkg::MAX_SCAN) ? MAX_BOXES : pbb_pkg::MAX_SCAN;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t state_r, state_nxt;
  logic [pbb_pkg::MARGIN_W-1:0] margin_r, margin_nxt;
  logic [pbb_pkg::COUNT_W-1:0]  box_count_r, box_count_nxt;
  logic [pbb_pkg::COUNT_W-1:0]  slots_r, slots_nxt;
  logic [pbb_pkg::COUNT_W-1:0]  limit_r, limit_nxt;
  logic [pbb_pkg::COUNT_W-1:0]  j_r, j_nxt;
  logic [pbb_pkg::BOX_W-1:0]    jj_r, jj_nxt;
  logic                         v_r, v_nxt;
  logic signed [pbb_pkg::COORD_W-1:0] pt_x_r, pt_x_nxt;
  logic signed [pbb_pkg::COORD_W-1:0] pt_y_r, pt_y_nxt;
  logic signed [pbb_pkg::COORD_W-1:0] pt_z_r, pt_z_nxt;
  logic [pbb_pkg::POINT_W-1:0]  pid_r, pid_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic [pbb_pkg::BOX_W-1:0]    pend_box_r, pend_box_nxt;
  logic [pbb_pkg::SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [pbb_pkg::CLASS_W-1:0]  pend_cls_r, pend_cls_nxt;
  logic                         out_v_r, out_v_nxt;
  pbb_pkg::out_item_t           out_r, out_nxt;

  logic                         in_acc;
  logic                         out_free;
  logic                         stall;
  logic                         eval;
  logic                         issue;
  logic                         box_we;
  logic                         fill_clr;
  logic                         fill_we;
  pbb_pkg::box_t                wr_box;
  pbb_pkg::box_t                rd_box;
  logic [pbb_pkg::COUNT_W-1:0]  fill_rd;
  pbb_pkg::hit_t                hu;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_v_r || out_chan.ready;
  assign stall    = (state_r == ST_SCAN) && v_r && hu.hit && pend_v_r && !out_free;
  assign eval     = (state_r == ST_SCAN) && v_r && !stall;
  assign issue    = (state_r == ST_SCAN) && !stall && (j_r < limit_r) &&
                    !(eval && hu.hit && hu.full);
  assign box_we   = in_acc && (in_chan.data.kind == pbb_pkg::KIND_LOAD) &&
                    (int'(in_chan.data.box_index) < MAX_BOXES);
  assign fill_clr = in_acc && (in_chan.data.kind == pbb_pkg::KIND_CLEAR);
  assign fill_we  = eval && hu.hit && !hu.full;

  assign wr_box.lo_x = in_chan.data.coord_x;
  assign wr_box.hi_x = in_chan.data.coord_x_hi;
  assign wr_box.lo_y = in_chan.data.coord_y;
  assign wr_box.hi_y = in_chan.data.coord_y_hi;
  assign wr_box.lo_z = in_chan.data.coord_z;
  assign wr_box.hi_z = in_chan.data.coord_z_hi;

  pbb_box_mem #(
    .MAX_BOXES (MAX_BOXES)
  ) u_mem (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (box_we),
    .wr_addr      (IDX_W'(in_chan.data.box_index)),
    .wr_box       (wr_box),
    .rd_en        (issue),
    .rd_addr      (IDX_W'(j_r)),
    .rd_box       (rd_box),
    .fill_rd      (fill_rd),
    .fill_clr     (fill_clr),
    .fill_we      (fill_we),
    .fill_wr_addr (IDX_W'(jj_r)),
    .fill_wr_data (pbb_pkg::COUNT_W'(fill_rd + 7'd1))
  );

  pbb_hit_unit u_hit (
    .pt_x   (pt_x_r),
    .pt_y   (pt_y_r),
    .pt_z   (pt_z_r),
    .box    (rd_box),
    .margin (margin_r),
    .fill   (fill_rd),
    .slots  (slots_r),
    .res    (hu)
  );

  always_comb begin
    state_nxt     = state_r;
    margin_nxt    = margin_r;
    box_count_nxt = box_count_r;
    slots_nxt     = slots_r;
    limit_nxt     = limit_r;
    j_nxt         = j_r;
    jj_nxt        = jj_r;
    v_nxt         = v_r;
    pt_x_nxt      = pt_x_r;
    pt_y_nxt      = pt_y_r;
    pt_z_nxt      = pt_z_r;
    pid_nxt       = pid_r;
    pend_v_nxt    = pend_v_r;
    pend_box_nxt  = pend_box_r;
    pend_slot_nxt = pend_slot_r;
    pend_cls_nxt  = pend_cls_r;
    out_nxt       = out_r;
    out_v_nxt     = out_v_r && !out_chan.ready;

    if (cfg_we) begin
      unique case (cfg_index)
        pbb_pkg::REG_MARGIN:    margin_nxt = cfg_data;
        pbb_pkg::REG_BOX_COUNT: box_count_nxt = pbb_pkg::COUNT_W'(cfg_data);
        pbb_pkg::REG_SLOTS:     slots_nxt = pbb_pkg::COUNT_W'(cfg_data);
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_chan.data.kind == pbb_pkg::KIND_PLACE)) begin
          pt_x_nxt   = in_chan.data.coord_x;
          pt_y_nxt   = in_chan.data.coord_y;
          pt_z_nxt   = in_chan.data.coord_z;
          pid_nxt    = in_chan.data.point_id;
          limit_nxt  = (box_count_r > pbb_pkg::COUNT_W'(LIM)) ?
                       pbb_pkg::COUNT_W'(LIM) : box_count_r;
          j_nxt      = '0;
          v_nxt      = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          v_nxt = issue;
          if (issue) begin
            j_nxt  = pbb_pkg::COUNT_W'(j_r + 7'd1);
            jj_nxt = j_r[pbb_pkg::BOX_W-1:0];
          end
          if (eval && hu.hit) begin
            if (pend_v_r) begin
              out_nxt.out_box     = pend_box_r;
              out_nxt.out_slot    = pend_slot_r;
              out_nxt.out_point   = pid_r;
              out_nxt.out_x       = pt_x_r;
              out_nxt.out_y       = pt_y_r;
              out_nxt.out_z       = pt_z_r;
              out_nxt.place_class = pend_cls_r;
              out_nxt.last        = 1'b0;
              out_v_nxt           = 1'b1;
            end
            pend_v_nxt    = 1'b1;
            pend_box_nxt  = jj_r;
            pend_slot_nxt = hu.full ? '0 : fill_rd[pbb_pkg::SLOT_W-1:0];
            pend_cls_nxt  = hu.cls;
            if (hu.full) begin
              v_nxt     = 1'b0;
              state_nxt = ST_FIN;
            end
          end
          if (!v_r && (j_r >= limit_r)) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_nxt.out_point = pid_r;
          out_nxt.out_x     = pt_x_r;
          out_nxt.out_y     = pt_y_r;
          out_nxt.out_z     = pt_z_r;
          out_nxt.last      = 1'b1;
          if (pend_v_r) begin
            out_nxt.out_box     = pend_box_r;
            out_nxt.out_slot    = pend_slot_r;
            out_nxt.place_class = pend_cls_r;
          end else begin
            out_nxt.out_box     = '0;
            out_nxt.out_slot    = '0;
            out_nxt.place_class = pbb_pkg::CLS_NOBOX;
          end
          out_v_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      margin_r    <= 31'd655;
      box_count_r <= '0;
      slots_r     <= 7'd64;
      limit_r     <= '0;
      j_r         <= '0;
      v_r         <= 1'b0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      margin_r    <= margin_nxt;
      box_count_r <= box_count_nxt;
      slots_r     <= slots_nxt;
      limit_r     <= limit_nxt;
      j_r         <= j_nxt;
      v_r         <= v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
    jj_r        <= jj_nxt;
    pt_x_r      <= pt_x_nxt;
    pt_y_r      <= pt_y_nxt;
    pt_z_r      <= pt_z_nxt;
    pid_r       <= pid_nxt;
    pend_box_r  <= pend_box_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_cls_r  <= pend_cls_nxt;
    out_r       <= out_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/pbb_box_mem.sv
`default_nettype none
module pbb_box_mem #(
  parameter int MAX_BOXES = 64,
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [IDX_W-1:0]              wr_addr,
  input  wire pbb_pkg::box_t                 wr_box,
  input  wire logic                          rd_en,
  input  wire logic [IDX_W-1:0]              rd_addr,
  output pbb_pkg::box_t                      rd_box,
  output logic [pbb_pkg::COUNT_W-1:0]        fill_rd,
  input  wire logic                          fill_clr,
  input  wire logic                          fill_we,
  input  wire logic [IDX_W-1:0]              fill_wr_addr,
  input  wire logic [pbb_pkg::COUNT_W-1:0]   fill_wr_data
);
  localparam int FILL_D = (MAX_BOXES < pbb_pkg::MAX_SCAN) ? MAX_BOXES : pbb_pkg::MAX_SCAN;
  localparam int FILL_W = (FILL_D > 1) ? $clog2(FILL_D) : 1;

  pbb_pkg::box_t               box_mem [MAX_BOXES];
  logic [pbb_pkg::COUNT_W-1:0] fill_mem [FILL_D];
  logic [FILL_D-1:0]           fill_vld_r;
  logic [FILL_W-1:0]           fill_ra;
  logic [FILL_W-1:0]           fill_wa;

  assign fill_ra = FILL_W'(rd_addr);
  assign fill_wa = FILL_W'(fill_wr_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_mem[wr_addr] <= wr_box;
    end
    if (rd_en) begin
      rd_box <= box_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wr_data;
    end
    if (rd_en) begin
      fill_rd <= fill_vld_r[fill_ra] ? fill_mem[fill_ra] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || fill_clr) begin
      fill_vld_r <= '0;
    end else if (fill_we) begin
      fill_vld_r[fill_wa] <= 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pbb_hit_unit.sv
`default_nettype none
module pbb_hit_unit (
  input  wire logic signed [pbb_pkg::COORD_W-1:0] pt_x,
  input  wire logic signed [pbb_pkg::COORD_W-1:0] pt_y,
  input  wire logic signed [pbb_pkg::COORD_W-1:0] pt_z,
  input  wire pbb_pkg::box_t                      box,
  input  wire logic [pbb_pkg::MARGIN_W-1:0]       margin,
  input  wire logic [pbb_pkg::COUNT_W-1:0]        fill,
  input  wire logic [pbb_pkg::COUNT_W-1:0]        slots,
  output pbb_pkg::hit_t                           res
);
  typedef struct packed {
    logic widened;
    logic outside;
    logic inner;
  } axis_t;

  function automatic axis_t axis_eval(
    input logic signed [pbb_pkg::COORD_W-1:0] c,
    input logic signed [pbb_pkg::COORD_W-1:0] lo,
    input logic signed [pbb_pkg::COORD_W-1:0] hi,
    input logic [pbb_pkg::MARGIN_W-1:0]       m
  );
    logic signed [33:0] c34;
    logic signed [33:0] lo34;
    logic signed [33:0] hi34;
    logic signed [33:0] m34;
    axis_t a;
    c34  = {{2{c[31]}}, c};
    lo34 = {{2{lo[31]}}, lo};
    hi34 = {{2{hi[31]}}, hi};
    m34  = {3'b000, m};
    a.widened = (c34 >= lo34 - m34) && (c34 <= hi34 + m34);
    a.outside = (c34 <= lo34) || (c34 >= hi34);
    a.inner   = (c34 > lo34 + m34) && (c34 < hi34 - m34);
    return a;
  endfunction

  axis_t ax;
  axis_t ay;
  axis_t az;
  logic [pbb_pkg::COUNT_W-1:0] cap;

  assign ax  = axis_eval(pt_x, box.lo_x, box.hi_x, margin);
  assign ay  = axis_eval(pt_y, box.lo_y, box.hi_y, margin);
  assign az  = axis_eval(pt_z, box.lo_z, box.hi_z, margin);
  assign cap = (slots > pbb_pkg::COUNT_W'(pbb_pkg::MAX_SLOTS)) ?
               pbb_pkg::COUNT_W'(pbb_pkg::MAX_SLOTS) : slots;

  always_comb begin
    res.hit  = ax.widened && ay.widened && az.widened;
    res.full = (fill >= cap);
    priority if (res.full) begin
      res.cls = pbb_pkg::CLS_FULL;
    end else if (ax.outside || ay.outside || az.outside) begin
      res.cls = pbb_pkg::CLS_HALO;
    end else if (ax.inner && ay.inner && az.inner) begin
      res.cls = pbb_pkg::CLS_INNER;
    end else begin
      res.cls = pbb_pkg::CLS_BAND;
    end
  end
endmodule
`default_nettype wire
